/* rtl/core/spn_pkg.sv */
// Shared types and constants for the SVG path segment normalizer.
// Holds segment kinds, internal operation codes and the queue entry layouts.
// No dependencies.
package spn_pkg;

  localparam int unsigned ArgWidth = 32;
  localparam int unsigned NumSlots = 6;

  typedef enum logic [3:0] {
    FUNC_MOVE   = 4'd0,
    FUNC_LINE   = 4'd1,
    FUNC_HORIZ  = 4'd2,
    FUNC_VERT   = 4'd3,
    FUNC_CUBIC  = 4'd4,
    FUNC_SCUBIC = 4'd5,
    FUNC_QUAD   = 4'd6,
    FUNC_SQUAD  = 4'd7,
    FUNC_ARC    = 4'd8,
    FUNC_CLOSE  = 4'd9
  } func_e;

  typedef enum logic [2:0] {
    KIND_MOVE  = 3'd0,
    KIND_LINE  = 3'd1,
    KIND_QUAD  = 3'd2,
    KIND_CUBIC = 3'd3,
    KIND_ARC   = 3'd4,
    KIND_CLOSE = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    OP_MOVE,
    OP_LINE,
    OP_CUBIC,
    OP_SCUBIC,
    OP_QUAD,
    OP_SQUAD,
    OP_ARC,
    OP_CLOSE
  } op_e;

  typedef logic signed [ArgWidth-1:0] arg_t;

  // Classified segment. Slots at even positions are x, at odd positions y.
  typedef struct packed {
    op_e                    op;
    logic                   rel;
    logic [NumSlots-1:0]    used;
    arg_t [NumSlots-1:0]    slot;
    logic                   large_arc;
    logic                   sweep;
  } seg_t;

  // Result entry; pt holds p1_x, p1_y, p2_x, p2_y, p3_x, p3_y in that order.
  typedef struct packed {
    kind_e                  kind;
    arg_t [NumSlots-1:0]    pt;
    logic                   large_arc;
    logic                   sweep;
    logic                   saturated;
  } res_t;

endpackage

/* rtl/core/spn_fifo.sv */
// Small synchronous queue built from flip-flops.
// Used between the front and back parts and on the result side.
// No package dependencies.
module spn_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth  = $clog2(Depth + 1);

  logic [Width-1:0]     mem_q [Depth];
  logic [AddrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0]  cnt_q;
  logic                 push_en, pop_en;

  assign full_o  = (cnt_q == CntWidth'(Depth));
  assign empty_o = (cnt_q == '0);
  assign push_en = push_i & ~full_o;
  assign pop_en  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_en) begin
        wr_ptr_q <= (wr_ptr_q == AddrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_en) begin
        rd_ptr_q <= (rd_ptr_q == AddrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_en && !pop_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_en && pop_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/core/spn_front.sv */
// Front part: accepts path segments and classifies them into operations.
// Routes the numbers of each segment kind into coordinate slots.
// Depends on spn_pkg.
module spn_front (
  input  logic                                   push_i,
  output logic                                   full_o,
  input  logic [3:0]                             func_i,
  input  logic                                   relative_i,
  input  spn_pkg::arg_t [spn_pkg::NumSlots-1:0]  arg_i,
  input  logic                                   large_arc_i,
  input  logic                                   sweep_i,
  input  logic                                   q_full_i,
  output logic                                   q_push_o,
  output spn_pkg::seg_t                          seg_o
);

  logic known;

  assign full_o   = q_full_i;
  assign q_push_o = push_i & ~q_full_i & known;

  always_comb begin
    known           = 1'b1;
    seg_o           = '0;
    seg_o.op        = spn_pkg::OP_CLOSE;
    seg_o.rel       = relative_i;
    seg_o.slot      = arg_i;
    seg_o.large_arc = large_arc_i;
    seg_o.sweep     = sweep_i;
    unique case (spn_pkg::func_e'(func_i))
      spn_pkg::FUNC_MOVE: begin
        seg_o.op   = spn_pkg::OP_MOVE;
        seg_o.used = 6'b000011;
      end
      spn_pkg::FUNC_LINE: begin
        seg_o.op   = spn_pkg::OP_LINE;
        seg_o.used = 6'b000011;
      end
      spn_pkg::FUNC_HORIZ: begin
        seg_o.op   = spn_pkg::OP_LINE;
        seg_o.used = 6'b000001;
      end
      spn_pkg::FUNC_VERT: begin
        seg_o.op      = spn_pkg::OP_LINE;
        seg_o.slot[1] = arg_i[0];
        seg_o.used    = 6'b000010;
      end
      spn_pkg::FUNC_CUBIC: begin
        seg_o.op   = spn_pkg::OP_CUBIC;
        seg_o.used = 6'b111111;
      end
      spn_pkg::FUNC_SCUBIC: begin
        seg_o.op      = spn_pkg::OP_SCUBIC;
        seg_o.slot[2] = arg_i[0];
        seg_o.slot[3] = arg_i[1];
        seg_o.slot[4] = arg_i[2];
        seg_o.slot[5] = arg_i[3];
        seg_o.used    = 6'b111100;
      end
      spn_pkg::FUNC_QUAD: begin
        seg_o.op   = spn_pkg::OP_QUAD;
        seg_o.used = 6'b001111;
      end
      spn_pkg::FUNC_SQUAD: begin
        seg_o.op      = spn_pkg::OP_SQUAD;
        seg_o.slot[2] = arg_i[0];
        seg_o.slot[3] = arg_i[1];
        seg_o.used    = 6'b001100;
      end
      spn_pkg::FUNC_ARC: begin
        // An arc with a zero radius is drawn as a straight line.
        seg_o.op      = ((arg_i[0] == '0) || (arg_i[1] == '0)) ? spn_pkg::OP_LINE
                                                               : spn_pkg::OP_ARC;
        seg_o.slot[0] = arg_i[3];
        seg_o.slot[1] = arg_i[4];
        seg_o.slot[2] = arg_i[0];
        seg_o.slot[3] = arg_i[1];
        seg_o.slot[4] = arg_i[2];
        seg_o.used    = 6'b000011;
      end
      spn_pkg::FUNC_CLOSE: begin
        seg_o.op = spn_pkg::OP_CLOSE;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/core/spn_back.sv */
// Back part: carries out classified segments against the path state.
// Holds the current point, subpath start and control point; saturating math.
// Depends on spn_pkg.
module spn_back #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spn_pkg::seg_t seg_i,
  input  logic          seg_valid_i,
  output logic          seg_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output spn_pkg::res_t res_o
);

  localparam int unsigned AW = spn_pkg::ArgWidth;
  localparam int unsigned NS = spn_pkg::NumSlots;
  localparam int unsigned WW = ((COORD_WIDTH > AW) ? COORD_WIDTH : AW) + 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [WW-1:0]          wide_t;

  function automatic wide_t ext_c(coord_t v);
    return {{(WW - COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
  endfunction

  function automatic wide_t ext_a(spn_pkg::arg_t v);
    return {{(WW - AW){v[AW-1]}}, v};
  endfunction

  function automatic logic fits(wide_t w);
    return (&w[WW-1:COORD_WIDTH-1]) | ~(|w[WW-1:COORD_WIDTH-1]);
  endfunction

  function automatic coord_t clip_val(wide_t w);
    coord_t r;
    if (fits(w)) begin
      r = w[COORD_WIDTH-1:0];
    end else if (w[WW-1]) begin
      r = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    end
    return r;
  endfunction

  function automatic spn_pkg::arg_t to32(coord_t v);
    wide_t w;
    w = ext_c(v);
    return w[AW-1:0];
  endfunction

  coord_t cur_x_q, cur_y_q, start_x_q, start_y_q, ctrl_x_q, ctrl_y_q;
  coord_t cur_x_d, cur_y_d, start_x_d, start_y_d, ctrl_x_d, ctrl_y_d;
  logic   ctrl_valid_q, subpath_open_q, need_move_q;
  logic   ctrl_valid_d, subpath_open_d, need_move_d;

  wide_t  dwx, dwy, rwx, rwy;
  coord_t dx, dy, refl_x, refl_y, bx, by, px0, py0;
  logic   refl_sat;
  wide_t  abs_w [NS];
  coord_t abs_v [NS];
  logic [NS-1:0] slot_sat;
  logic   go;

  assign go         = seg_valid_i & ~res_full_i;
  assign seg_pop_o  = go;
  assign res_push_o = go;

  // Reflection of the stored control point about the current point.
  assign dwx    = ext_c(cur_x_q) - ext_c(ctrl_x_q);
  assign dwy    = ext_c(cur_y_q) - ext_c(ctrl_y_q);
  assign dx     = clip_val(dwx);
  assign dy     = clip_val(dwy);
  assign rwx    = ext_c(cur_x_q) + ext_c(dx);
  assign rwy    = ext_c(cur_y_q) + ext_c(dy);
  assign refl_x = clip_val(rwx);
  assign refl_y = clip_val(rwy);
  assign refl_sat = ~fits(dwx) | ~fits(dwy) | ~fits(rwx) | ~fits(rwy);
  assign bx     = ctrl_valid_q ? refl_x : cur_x_q;
  assign by     = ctrl_valid_q ? refl_y : cur_y_q;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (seg_i.rel) begin
        abs_w[k] = ext_c((k % 2 != 0) ? cur_y_q : cur_x_q) + ext_a(seg_i.slot[k]);
      end else begin
        abs_w[k] = ext_a(seg_i.slot[k]);
      end
      abs_v[k]    = clip_val(abs_w[k]);
      slot_sat[k] = seg_i.used[k] & ~fits(abs_w[k]);
    end
  end

  assign px0 = seg_i.used[0] ? abs_v[0] : cur_x_q;
  assign py0 = seg_i.used[1] ? abs_v[1] : cur_y_q;

  always_comb begin
    cur_x_d        = cur_x_q;
    cur_y_d        = cur_y_q;
    start_x_d      = start_x_q;
    start_y_d      = start_y_q;
    ctrl_x_d       = ctrl_x_q;
    ctrl_y_d       = ctrl_y_q;
    ctrl_valid_d   = ctrl_valid_q;
    subpath_open_d = subpath_open_q;
    need_move_d    = (seg_i.op == spn_pkg::OP_CLOSE);
    res_o           = '0;
    res_o.kind      = spn_pkg::KIND_CLOSE;
    res_o.saturated = (ctrl_valid_q & refl_sat) | (|slot_sat);
    unique case (seg_i.op)
      spn_pkg::OP_MOVE: begin
        res_o.kind     = spn_pkg::KIND_MOVE;
        res_o.pt[0]    = to32(px0);
        res_o.pt[1]    = to32(py0);
        cur_x_d        = px0;
        cur_y_d        = py0;
        start_x_d      = px0;
        start_y_d      = py0;
        subpath_open_d = 1'b1;
        ctrl_valid_d   = 1'b0;
      end
      spn_pkg::OP_LINE: begin
        res_o.kind   = need_move_q ? spn_pkg::KIND_MOVE : spn_pkg::KIND_LINE;
        res_o.pt[0]  = to32(px0);
        res_o.pt[1]  = to32(py0);
        cur_x_d      = px0;
        cur_y_d      = py0;
        ctrl_valid_d = 1'b0;
      end
      spn_pkg::OP_CUBIC, spn_pkg::OP_SCUBIC: begin
        res_o.kind   = spn_pkg::KIND_CUBIC;
        res_o.pt[0]  = (seg_i.op == spn_pkg::OP_SCUBIC) ? to32(bx) : to32(abs_v[0]);
        res_o.pt[1]  = (seg_i.op == spn_pkg::OP_SCUBIC) ? to32(by) : to32(abs_v[1]);
        res_o.pt[2]  = to32(abs_v[2]);
        res_o.pt[3]  = to32(abs_v[3]);
        res_o.pt[4]  = to32(abs_v[4]);
        res_o.pt[5]  = to32(abs_v[5]);
        ctrl_x_d     = abs_v[2];
        ctrl_y_d     = abs_v[3];
        cur_x_d      = abs_v[4];
        cur_y_d      = abs_v[5];
        ctrl_valid_d = 1'b1;
      end
      spn_pkg::OP_QUAD, spn_pkg::OP_SQUAD: begin
        res_o.kind   = spn_pkg::KIND_QUAD;
        ctrl_x_d     = (seg_i.op == spn_pkg::OP_SQUAD) ? bx : abs_v[0];
        ctrl_y_d     = (seg_i.op == spn_pkg::OP_SQUAD) ? by : abs_v[1];
        res_o.pt[0]  = to32(ctrl_x_d);
        res_o.pt[1]  = to32(ctrl_y_d);
        res_o.pt[2]  = to32(abs_v[2]);
        res_o.pt[3]  = to32(abs_v[3]);
        cur_x_d      = abs_v[2];
        cur_y_d      = abs_v[3];
        ctrl_valid_d = 1'b1;
      end
      spn_pkg::OP_ARC: begin
        res_o.kind      = spn_pkg::KIND_ARC;
        res_o.pt[0]     = seg_i.slot[2];
        res_o.pt[1]     = seg_i.slot[3];
        res_o.pt[2]     = to32(abs_v[0]);
        res_o.pt[3]     = to32(abs_v[1]);
        res_o.pt[4]     = seg_i.slot[4];
        res_o.large_arc = seg_i.large_arc;
        res_o.sweep     = seg_i.sweep;
        cur_x_d         = abs_v[0];
        cur_y_d         = abs_v[1];
        ctrl_valid_d    = 1'b0;
      end
      spn_pkg::OP_CLOSE: begin
        res_o.kind = spn_pkg::KIND_CLOSE;
        if (subpath_open_q) begin
          cur_x_d        = start_x_q;
          cur_y_d        = start_y_q;
          subpath_open_d = 1'b0;
        end
      end
      default: begin
        res_o.kind = spn_pkg::KIND_CLOSE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q        <= '0;
      cur_y_q        <= '0;
      start_x_q      <= '0;
      start_y_q      <= '0;
      ctrl_x_q       <= '0;
      ctrl_y_q       <= '0;
      ctrl_valid_q   <= 1'b0;
      subpath_open_q <= 1'b0;
      need_move_q    <= 1'b1;
    end else if (go) begin
      cur_x_q        <= cur_x_d;
      cur_y_q        <= cur_y_d;
      start_x_q      <= start_x_d;
      start_y_q      <= start_y_d;
      ctrl_x_q       <= ctrl_x_d;
      ctrl_y_q       <= ctrl_y_d;
      ctrl_valid_q   <= ctrl_valid_d;
      subpath_open_q <= subpath_open_d;
      need_move_q    <= need_move_d;
    end
  end

endmodule

/* rtl/core/svg_path_segment_normalizer_core.sv */
// Top level of the SVG path segment normalizer; needs spn_pkg, spn_front,
// spn_fifo and spn_back. An accepted segment passes the segment queue, the
// back part and the result queue, from which it is popped; one segment per
// cycle is sustained while the result queue is not full. Unknown kinds are
// taken and dropped. Reset empties both queues, clears the path state and
// sets the pending-move flag.
module svg_path_segment_normalizer_core #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [3:0]         func_i,
  input  logic               relative_i,
  input  logic signed [31:0] arg0_i,
  input  logic signed [31:0] arg1_i,
  input  logic signed [31:0] arg2_i,
  input  logic signed [31:0] arg3_i,
  input  logic signed [31:0] arg4_i,
  input  logic signed [31:0] arg5_i,
  input  logic               large_arc_i,
  input  logic               sweep_i,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         out_kind_o,
  output logic signed [31:0] p1_x_o,
  output logic signed [31:0] p1_y_o,
  output logic signed [31:0] p2_x_o,
  output logic signed [31:0] p2_y_o,
  output logic signed [31:0] p3_x_o,
  output logic signed [31:0] p3_y_o,
  output logic               out_large_arc_o,
  output logic               out_sweep_o,
  output logic               saturated_o
);

  localparam int unsigned SegWidth = $bits(spn_pkg::seg_t);
  localparam int unsigned ResWidth = $bits(spn_pkg::res_t);

  spn_pkg::arg_t [spn_pkg::NumSlots-1:0] args;
  spn_pkg::seg_t seg_in, seg_out;
  spn_pkg::res_t res_in, res_out;
  logic          seg_push, seg_full, seg_empty, seg_pop;
  logic          res_push, res_full;

  assign args = {arg5_i, arg4_i, arg3_i, arg2_i, arg1_i, arg0_i};

  spn_front u_front (
    .push_i      (push),
    .full_o      (full),
    .func_i      (func_i),
    .relative_i  (relative_i),
    .arg_i       (args),
    .large_arc_i (large_arc_i),
    .sweep_i     (sweep_i),
    .q_full_i    (seg_full),
    .q_push_o    (seg_push),
    .seg_o       (seg_in)
  );

  spn_fifo #(
    .Width (SegWidth),
    .Depth (2)
  ) u_seg_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (seg_push),
    .wdata_i (seg_in),
    .full_o  (seg_full),
    .pop_i   (seg_pop),
    .rdata_o (seg_out),
    .empty_o (seg_empty)
  );

  spn_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_i       (seg_out),
    .seg_valid_i (~seg_empty),
    .seg_pop_o   (seg_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  spn_fifo #(
    .Width (ResWidth),
    .Depth (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign out_kind_o      = res_out.kind;
  assign p1_x_o          = res_out.pt[0];
  assign p1_y_o          = res_out.pt[1];
  assign p2_x_o          = res_out.pt[2];
  assign p2_y_o          = res_out.pt[3];
  assign p3_x_o          = res_out.pt[4];
  assign p3_y_o          = res_out.pt[5];
  assign out_large_arc_o = res_out.large_arc;
  assign out_sweep_o     = res_out.sweep;
  assign saturated_o     = res_out.saturated;

endmodule

/* rtl/core/spn_checker.sv */
// Port-level checks for the SVG path segment normalizer.
// Bound to svg_path_segment_normalizer_core; depends on spn_pkg.
module spn_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [2:0]         out_kind_o,
  input logic signed [31:0] p1_x_o,
  input logic signed [31:0] p1_y_o,
  input logic signed [31:0] p2_x_o,
  input logic signed [31:0] p2_y_o,
  input logic signed [31:0] p3_x_o,
  input logic signed [31:0] p3_y_o,
  input logic               out_large_arc_o,
  input logic               out_sweep_o,
  input logic               saturated_o
);

  // A waiting result's kind, points and saturation flag must not change until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_kind_o) && $stable(p1_x_o) &&
      $stable(p1_y_o) && $stable(p2_x_o) && $stable(p2_y_o) && $stable(p3_x_o) &&
      $stable(p3_y_o) && $stable(saturated_o)))
    else $error("result changed while stalled");

  a_close_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_kind_o == spn_pkg::KIND_CLOSE) |->
      (p1_x_o == 0 && p1_y_o == 0 && p2_x_o == 0 && p2_y_o == 0 &&
       p3_x_o == 0 && p3_y_o == 0))
    else $error("close result carries coordinates");

  a_arc_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_kind_o != spn_pkg::KIND_ARC) |-> (!out_large_arc_o && !out_sweep_o))
    else $error("arc flags set on a non-arc result");

  a_reset: assert property (@(posedge clk_i) !rst_ni |-> (empty && !full))
    else $error("queues not empty in reset");

endmodule

bind svg_path_segment_normalizer_core spn_checker u_spn_checker (.*);
